// ===== src/assert_macros.svh =====
// Assertion macros for the PCX plane decoder.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define PCXD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pcxd assertion failed");

// Antecedent this cycle implies consequent next cycle.
`define PCXD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcxd assertion failed");

`endif

// ===== src/pcxd_pkg.sv =====
// Shared types and constants for the PCX run-length plane decoder.
// No dependencies.
package pcxd_pkg;

    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [7:0] RUN_MASK = 8'h3F;

    localparam logic [2:0] REG_PIXEL_MODE     = 3'd0;
    localparam logic [2:0] REG_BYTES_PER_LINE = 3'd1;
    localparam logic [2:0] REG_PLANE_COUNT    = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd4;

    localparam logic KIND_PLANAR = 1'b0;
    localparam logic KIND_STORE  = 1'b1;

    // scan-line position
    typedef struct packed {
        logic [15:0] line_cnt;
        logic [2:0]  plane;
        logic [15:0] row;
    } t_pos;

    // one pixel write
    typedef struct packed {
        logic [23:0] addr;
        logic [7:0]  bits;
        logic [2:0]  plane;
        logic        kind;
    } t_pix;

endpackage

// ===== src/pcxd_write_unit.sv =====
// Shared write unit: one pixel write and the scan-line bookkeeping.
// Depends on pcxd_pkg.
module pcxd_write_unit #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                    i_mode,
    input  logic [15:0]             i_bpl,
    input  logic [3:0]              i_planes,
    input  logic [15:0]             i_width,
    input  logic [15:0]             i_height,
    input  logic [31:0]             i_limit,
    input  logic [7:0]              i_byte,
    input  logic [ADDRESS_BITS-1:0] i_addr,
    input  logic [ADDRESS_BITS-1:0] i_row_start,
    input  pcxd_pkg::t_pos          i_pos,
    output logic                    o_made,
    output pcxd_pkg::t_pix          o_pix,
    output logic [ADDRESS_BITS-1:0] o_addr_n,
    output logic [ADDRESS_BITS-1:0] o_row_start_n,
    output pcxd_pkg::t_pos          o_pos_n,
    output logic                    o_finish
);
    import pcxd_pkg::*;

    logic [32:0] rem;
    logic        rem_small;
    logic [7:0]  keep;
    logic [3:0]  eff_planes;
    logic [3:0]  plane_inc;
    logic [15:0] line_n;
    logic [15:0] row_n;
    logic [ADDRESS_BITS-1:0] row_start_inc;

    assign rem       = {1'b0, i_limit} - {1'b0, 32'(i_addr)};
    assign o_made    = ({1'b0, 32'(i_addr)} < {1'b0, i_limit});
    assign rem_small = (rem[32:3] == '0);

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            keep[7-k] = !rem_small || (3'(k) < rem[2:0]);
        end
    end

    always_comb begin
        o_pix.addr  = 24'(i_addr);
        o_pix.bits  = (i_mode == KIND_STORE) ? i_byte : (i_byte & keep);
        o_pix.plane = i_pos.plane;
        o_pix.kind  = i_mode;
    end

    assign eff_planes    = (i_planes == 4'd0) ? 4'd1 : ((i_planes > 4'd8) ? 4'd8 : i_planes);
    assign plane_inc     = {1'b0, i_pos.plane} + 4'd1;
    assign line_n        = i_pos.line_cnt + 16'd1;
    assign row_n         = i_pos.row + 16'd1;
    assign row_start_inc = i_row_start + ADDRESS_BITS'(i_width);

    always_comb begin
        o_addr_n      = i_addr + ((i_mode == KIND_STORE) ? ADDRESS_BITS'(1) : ADDRESS_BITS'(8));
        o_row_start_n = i_row_start;
        o_pos_n       = i_pos;
        o_pos_n.line_cnt = line_n;
        o_finish      = 1'b0;
        if (line_n == i_bpl) begin
            o_pos_n.line_cnt = '0;
            if (plane_inc >= eff_planes) begin
                o_pos_n.plane = '0;
                o_row_start_n = row_start_inc;
                o_addr_n      = row_start_inc;
                o_pos_n.row   = row_n;
                o_finish      = (row_n >= i_height);
            end else begin
                o_pos_n.plane = plane_inc[2:0];
                o_addr_n      = i_row_start;
            end
        end
    end

endmodule

// ===== src/pcxd_out_stage.sv =====
// Output stage: holds one write back until the next or the end of the item.
// Depends on pcxd_pkg.
module pcxd_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcxd_pkg::t_pix i_pix,
    input  logic           i_flush,
    input  logic           i_done,
    output logic           o_free,
    output logic           o_pend_valid,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [39:0]    o_m_tdata,  // pixel_address[23:0], pixel_bits, plane_index, zero fill
    output logic [1:0]     o_m_tuser,  // write_kind, image_done
    output logic           o_m_tlast
);
    import pcxd_pkg::*;

    logic r_pend_valid, n_pend_valid;
    logic r_out_valid, n_out_valid;
    t_pix r_pend, n_pend;
    t_pix r_out, n_out;
    logic r_last, n_last;
    logic r_done, n_done;

    assign o_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_out;
        n_last       = r_last;
        n_done       = r_done;
        n_out_valid  = r_out_valid && !i_m_tready;
        if (i_push && o_free) begin
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_last      = 1'b0;
                n_done      = 1'b0;
                n_out_valid = 1'b1;
            end
            n_pend       = i_pix;
            n_pend_valid = 1'b1;
        end else if (i_flush && o_free && r_pend_valid) begin
            n_out        = r_pend;
            n_last       = 1'b1;
            n_done       = i_done;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
        r_last <= n_last;
        r_done <= n_done;
    end

    assign o_pend_valid = r_pend_valid;
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {5'b0, r_out.plane, r_out.bits, r_out.addr};
    assign o_m_tuser    = {r_done, r_out.kind};
    assign o_m_tlast    = r_last;

endmodule

// ===== src/pcx_rle_plane_decoder.sv =====
// PCX run-length plane decoder, top level: config, sequencer, write unit, output stage.
// The first write of an item is formed in S_RUN, held in the output stage, and offered
// when the next write or S_FLUSH moves it out. Writes go one per cycle through the shared
// write unit while the output stage is free; a count byte is taken without leaving S_IDLE.
// Reset: synchronous, active low; registers to defaults, decoder state cleared.
// Depends on pcxd_pkg, pcxd_write_unit, pcxd_out_stage, assert_macros.svh.
`include "assert_macros.svh"
module pcx_rle_plane_decoder #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // coded_byte
    input  logic        i_s_tuser,   // start_image
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // pixel_address[23:0], pixel_bits, plane_index, zero fill
    output logic [1:0]  o_m_tuser,   // write_kind, image_done
    output logic        o_m_tlast    // last_of_run
);
    import pcxd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic        r_mode;
    logic [15:0] r_bpl;
    logic [3:0]  r_planes;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_limit;

    logic        r_run_pending, n_run_pending;
    logic [5:0]  r_repeat, n_repeat;
    logic [5:0]  r_cnt, n_cnt;
    logic [7:0]  r_byte, n_byte;
    t_pos        r_pos, n_pos;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [ADDRESS_BITS-1:0] r_row_start, n_row_start;
    logic        r_finished, n_finished;

    logic        accept;
    logic        out_free;
    logic        pend_valid;
    logic        wr_made;
    t_pix        wr_pix;
    logic [ADDRESS_BITS-1:0] wr_addr_n;
    logic [ADDRESS_BITS-1:0] wr_row_start_n;
    t_pos        wr_pos_n;
    logic        wr_finish;
    logic        push;
    logic        flush;

    logic        e_pending;
    logic [5:0]  e_repeat;
    logic        e_finished;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_bpl    <= 16'd1;
            r_planes <= 4'd1;
            r_width  <= 16'd1;
            r_height <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PIXEL_MODE:     r_mode   <= i_cfg_data[0];
                REG_BYTES_PER_LINE: r_bpl    <= i_cfg_data;
                REG_PLANE_COUNT:    r_planes <= i_cfg_data[3:0];
                REG_IMAGE_WIDTH:    r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT:   r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= 32'(r_width) * 32'(r_height);
    end

    pcxd_write_unit #(.ADDRESS_BITS(ADDRESS_BITS)) u_write (
        .i_mode        (r_mode),
        .i_bpl         (r_bpl),
        .i_planes      (r_planes),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_limit       (r_limit),
        .i_byte        (r_byte),
        .i_addr        (r_addr),
        .i_row_start   (r_row_start),
        .i_pos         (r_pos),
        .o_made        (wr_made),
        .o_pix         (wr_pix),
        .o_addr_n      (wr_addr_n),
        .o_row_start_n (wr_row_start_n),
        .o_pos_n       (wr_pos_n),
        .o_finish      (wr_finish)
    );

    assign push  = (r_state == S_RUN) && out_free && wr_made;
    assign flush = (r_state == S_FLUSH);

    pcxd_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pix        (wr_pix),
        .i_flush      (flush),
        .i_done       (r_finished),
        .o_free       (out_free),
        .o_pend_valid (pend_valid),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

    assign e_pending  = i_s_tuser ? 1'b0 : r_run_pending;
    assign e_repeat   = i_s_tuser ? 6'd0 : r_repeat;
    assign e_finished = i_s_tuser ? 1'b0 : r_finished;

    always_comb begin
        n_state       = r_state;
        n_run_pending = r_run_pending;
        n_repeat      = r_repeat;
        n_cnt         = r_cnt;
        n_byte        = r_byte;
        n_pos         = r_pos;
        n_addr        = r_addr;
        n_row_start   = r_row_start;
        n_finished    = r_finished;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser) begin
                        n_run_pending = 1'b0;
                        n_repeat      = '0;
                        n_pos         = '0;
                        n_addr        = '0;
                        n_row_start   = '0;
                        n_finished    = 1'b0;
                    end
                    if (!e_finished) begin
                        if (e_pending) begin
                            n_run_pending = 1'b0;
                            n_repeat      = '0;
                            if (e_repeat != 6'd0) begin
                                n_cnt   = e_repeat;
                                n_byte  = i_s_tdata;
                                n_state = S_RUN;
                            end
                        end else if ((i_s_tdata & RUN_MARK) == RUN_MARK) begin
                            n_run_pending = 1'b1;
                            n_repeat      = 6'(i_s_tdata & RUN_MASK);
                        end else begin
                            n_cnt   = 6'd1;
                            n_byte  = i_s_tdata;
                            n_state = S_RUN;
                        end
                    end
                end
            end
            S_RUN: begin
                if (out_free) begin
                    n_addr      = wr_addr_n;
                    n_row_start = wr_row_start_n;
                    n_pos       = wr_pos_n;
                    n_finished  = wr_finish;
                    n_cnt       = r_cnt - 6'd1;
                    if (r_cnt == 6'd1 || wr_finish) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_valid || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_run_pending <= 1'b0;
            r_repeat      <= '0;
            r_cnt         <= '0;
            r_pos         <= '0;
            r_addr        <= '0;
            r_row_start   <= '0;
            r_finished    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_run_pending <= n_run_pending;
            r_repeat      <= n_repeat;
            r_cnt         <= n_cnt;
            r_pos         <= n_pos;
            r_addr        <= n_addr;
            r_row_start   <= n_row_start;
            r_finished    <= n_finished;
        end
        r_byte <= n_byte;
    end

    `PCXD_ASSERT(a_run_not_finished, (r_state != S_RUN) || !r_finished)
    `PCXD_ASSERT(a_run_cnt_nonzero, (r_state != S_RUN) || (r_cnt != 6'd0))
    `PCXD_ASSERT(a_idle_no_pending, (r_state != S_IDLE) || !pend_valid)
    `PCXD_ASSERT(a_done_on_last, !(o_m_tvalid && o_m_tuser[1]) || o_m_tlast)
    `PCXD_ASSERT_NEXT(a_flush_to_idle, (r_state == S_FLUSH) && out_free, r_state == S_IDLE)

endmodule

// ===== bench/pcx_rle_plane_decoder_test.sv =====
// Self-checking bench for pcx_rle_plane_decoder: coded bytes in, pixel writes out,
// each write checked field by field against a decoder model kept in the bench.
// Depends on pcxd_pkg and the RTL of the decoder.
`timescale 1ns / 1ps
module pcx_rle_plane_decoder_test;
    import pcxd_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_GAP   = 200;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] code;
        logic       start;
    } coded_item_t;

    typedef struct packed {
        logic [23:0] addr;
        logic [7:0]  bits;
        logic [2:0]  plane;
        logic        kind;
        logic        last;
        logic        done;
    } pix_write_t;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = REG_PIXEL_MODE;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    pcx_rle_plane_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    coded_item_t coded_items_pending[$];
    pix_write_t  pixel_writes_due[$];
    coded_item_t next_item;
    pix_write_t  due_write;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int field_errs;
    int bytes_taken = 0;
    int writes_checked = 0;
    int settings_loaded = 0;

    // decoder model: settings
    logic        cfg_mode = KIND_PLANAR;
    logic [15:0] cfg_bpl = 16'd1;
    logic [3:0]  cfg_planes = 4'd1;
    logic [15:0] cfg_width = 16'd1;
    logic [15:0] cfg_height = 16'd1;

    // decoder model: state
    bit          run_armed = 1'b0;
    logic [5:0]  run_len = '0;
    logic [15:0] line_pos = '0;
    logic [2:0]  cur_plane = '0;
    logic [15:0] cur_row = '0;
    logic [23:0] wr_addr = '0;
    logic [23:0] row_addr = '0;
    bit          img_done = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic decode_byte(input logic [7:0] code, input logic start);
        int unsigned reps;
        logic [31:0] limit;
        logic [31:0] a32;
        logic [7:0]  bits;
        logic [3:0]  planes_eff;
        pix_write_t  held;
        bit          have_held;
        have_held = 1'b0;
        held = '0;
        if (start) begin
            run_armed = 1'b0;
            run_len = '0;
            line_pos = '0;
            cur_plane = '0;
            cur_row = '0;
            wr_addr = '0;
            row_addr = '0;
            img_done = 1'b0;
        end
        if (img_done)
            return;
        if (run_armed) begin
            reps = run_len;
            run_armed = 1'b0;
            run_len = '0;
        end else if ((code & RUN_MARK) == RUN_MARK) begin
            run_armed = 1'b1;
            run_len = 6'(code & RUN_MASK);
            return;
        end else begin
            reps = 1;
        end
        for (int i = 0; i < reps && !img_done; i++) begin
            limit = cfg_width * cfg_height;
            a32 = {8'h00, wr_addr};
            if (a32 < limit) begin
                bits = code;
                if (cfg_mode == KIND_PLANAR) begin
                    for (int k = 0; k < 8; k++)
                        if (a32 + k >= limit)
                            bits[7-k] = 1'b0;
                end
                if (have_held)
                    pixel_writes_due.push_back(held);
                held = '{addr: wr_addr, bits: bits, plane: cur_plane, kind: cfg_mode,
                         last: 1'b0, done: 1'b0};
                have_held = 1'b1;
            end
            wr_addr = wr_addr + ((cfg_mode == KIND_PLANAR) ? 24'd8 : 24'd1);
            line_pos = line_pos + 16'd1;
            if (line_pos == cfg_bpl) begin
                line_pos = '0;
                planes_eff = (cfg_planes == 4'd0) ? 4'd1 :
                             (cfg_planes > 4'd8) ? 4'd8 : cfg_planes;
                if ({1'b0, cur_plane} + 4'd1 >= planes_eff) begin
                    cur_plane = '0;
                    row_addr = row_addr + {8'h00, cfg_width};
                    wr_addr = row_addr;
                    cur_row = cur_row + 16'd1;
                    if (cur_row >= cfg_height)
                        img_done = 1'b1;
                end else begin
                    cur_plane = cur_plane + 3'd1;
                    wr_addr = row_addr;
                end
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            held.done = img_done;
            pixel_writes_due.push_back(held);
        end
    endtask

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // source side
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                decode_byte(s_tdata, s_tuser);
                bytes_taken++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (coded_items_pending.size() != 0 &&
                    $urandom_range(0, 99) >= src_idle_pct) begin
                    next_item = coded_items_pending.pop_front();
                    s_tdata <= next_item.code;
                    s_tuser <= next_item.start;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (pixel_writes_due.size() == 0) begin
                    $display("%0t: unexpected write: expected none, actual %h last %b user %b",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser);
                    fail_count++;
                end else begin
                    due_write = pixel_writes_due.pop_front();
                    field_errs = field_diff("pixel_address", due_write.addr, o_m_tdata[23:0])
                        + field_diff("pixel_bits", due_write.bits, o_m_tdata[31:24])
                        + field_diff("plane_index", due_write.plane, o_m_tdata[34:32])
                        + field_diff("write_kind", due_write.kind, o_m_tuser[0])
                        + field_diff("image_done", due_write.done, o_m_tuser[1])
                        + field_diff("last_of_run", due_write.last, o_m_tlast);
                    if (field_errs != 0)
                        fail_count++;
                    writes_checked++;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d writes outstanding",
                     $time, QUIET_LIMIT, pixel_writes_due.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic offer(input logic [7:0] code, input logic start);
        coded_items_pending.push_back('{code: code, start: start});
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            REG_PIXEL_MODE:     cfg_mode = val[0];
            REG_BYTES_PER_LINE: cfg_bpl = val;
            REG_PLANE_COUNT:    cfg_planes = val[3:0];
            REG_IMAGE_WIDTH:    cfg_width = val;
            REG_IMAGE_HEIGHT:   cfg_height = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic mode, input logic [15:0] bpl,
                                 input logic [3:0] planes, input logic [15:0] width,
                                 input logic [15:0] height);
        put_reg(REG_PIXEL_MODE, {15'd0, mode});
        put_reg(REG_BYTES_PER_LINE, bpl);
        put_reg(REG_PLANE_COUNT, {12'd0, planes});
        put_reg(REG_IMAGE_WIDTH, width);
        put_reg(REG_IMAGE_HEIGHT, height);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_loaded++;
        @(negedge i_clk);
    endtask

    // wait for every byte taken and every write seen, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        while (coded_items_pending.size() != 0 || s_tvalid || pixel_writes_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    // mostly count/data pairs and literals, grouped into images; some stray bytes
    task automatic queue_random_stream(input int n);
        int made;
        int left_in_image;
        int sel;
        logic start;
        made = 0;
        left_in_image = 0;
        while (made < n) begin
            start = (left_in_image == 0);
            if (start)
                left_in_image = $urandom_range(4, 12);
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                offer(RUN_MARK | 8'($urandom_range(0, 63)), start);
                offer(8'($urandom_range(0, 255)), 1'b0);
                made += 2;
            end else if (sel < 8) begin
                offer(8'($urandom_range(0, 191)), start);
                made++;
            end else begin
                offer(8'($urandom_range(0, 255)), start | 1'($urandom_range(0, 1)));
                made++;
            end
            left_in_image--;
        end
    endtask

    task automatic random_phase(input logic mode, input logic [15:0] bpl,
                                input logic [3:0] planes, input logic [15:0] width,
                                input logic [15:0] height, input int n);
        load_settings(mode, bpl, planes, width, height);
        queue_random_stream(n);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct = 29;
        snk_idle_pct = 86;
        // reset settings: one-pixel image, planar write clipped to its top bit
        offer(8'hC5, 1'b1);
        offer(8'h81, 1'b0);
        offer(8'h12, 1'b0);
        offer(8'h40, 1'b1);
        offer(8'hC2, 1'b1);
        offer(8'h3C, 1'b0);
        drain();

        load_settings(KIND_PLANAR, 16'd4, 4'd3, 16'd16, 16'd2);
        offer(8'h00, 1'b1);
        offer(8'hC0, 1'b0);   // zero repeat
        offer(8'hAA, 1'b0);
        offer(8'hFF, 1'b0);   // long run, overruns the image and finishes it
        offer(8'h55, 1'b0);
        offer(8'h7F, 1'b0);   // ignored once finished
        offer(8'hBF, 1'b1);
        offer(8'hC1, 1'b0);
        offer(8'hC0, 1'b0);   // data byte that looks like a count
        offer(8'hC2, 1'b0);
        offer(8'hFF, 1'b0);
        offer(8'hC5, 1'b0);   // count byte, then restart drops it
        offer(8'hC3, 1'b1);
        offer(8'h01, 1'b0);
        offer(8'hFE, 1'b0);
        offer(8'h80, 1'b0);
        drain();

        random_phase(KIND_STORE, 16'd7, 4'd1, 16'd5, 16'd3, 20);

        src_idle_pct = 86;
        snk_idle_pct = 29;
        hold_req = 1'b1;
        random_phase(KIND_PLANAR, 16'd2, 4'd8, 16'd16, 16'd4, 20);
        random_phase(KIND_PLANAR, 16'd3, 4'd0, 16'hFFFF, 16'd0, 8);
        random_phase(KIND_STORE, 16'hFFFF, 4'd15, 16'd1, 16'hFFFF, 15);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(KIND_PLANAR, 16'd0, 4'd2, 16'd24, 16'd1, 10);
        random_phase(KIND_STORE, 16'd1, 4'd8, 16'd3, 16'd5, 20);
        random_phase(KIND_PLANAR, 16'd2, 4'd1, 16'd8, 16'd2, 20);

        if (pixel_writes_due.size() != 0) begin
            $display("%0t: %0d expected writes never arrived", $time, pixel_writes_due.size());
            fail_count++;
        end
        $display("Decoded %0d coded bytes under %0d register settings, %0d pixel writes checked,",
                 bytes_taken, settings_loaded, writes_checked);
        $display("both pixel modes, clipped and dropped writes, and a long output stall.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
